// ----- rtl/core/mrhb_pkg.sv -----
// shared types and constants of the multi-ring history buffer
package mrhb_pkg;

  localparam int unsigned RingDepthDef = 16;
  localparam int unsigned RingCountDef = 4;

  localparam int unsigned FuncW  = 2;
  localparam int unsigned BufIdW = 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_QUERY = 2'd3
  } func_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic do_write;
    logic do_clear;
    logic load_status;
    logic start_read;
    logic next_read;
    logic load_word;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic slot_free;
    logic read_empty;
    logic run_last;
  } ctrl_sts_t;

endpackage

// ----- rtl/core/mrhb_if.sv -----
// request and response channel interfaces
interface mrhb_req_if;
  logic                           valid;
  logic                           ready;
  logic [mrhb_pkg::FuncW-1:0]     func;
  logic [mrhb_pkg::BufIdW-1:0]    buffer_id;
  logic [mrhb_pkg::DataW-1:0]     data_in;

  modport source (output valid, func, buffer_id, data_in, input ready);
  modport sink   (input valid, func, buffer_id, data_in, output ready);
endinterface

interface mrhb_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mrhb_pkg::DataW-1:0]     data_out;
  logic [mrhb_pkg::CountW-1:0]    count;
  logic                           has_data;
  logic                           last;

  modport source (output valid, data_out, count, has_data, last, input ready);
  modport sink   (input valid, data_out, count, has_data, last, output ready);
endinterface

// ----- rtl/core/mrhb_ram.sv -----
// generic simple dual-port ram with registered read
module mrhb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mrhb_ctrl.sv -----
// controller state machine: decodes items and sequences the drain of a ring
module mrhb_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [mrhb_pkg::FuncW-1:0] in_func_i,
  output logic                       in_ready_o,
  input  mrhb_pkg::ctrl_sts_t        sts_i,
  output mrhb_pkg::ctrl_cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mrhb_pkg::func_e'(in_func_i))
            mrhb_pkg::FUNC_WRITE: cmd_o.do_write    = 1'b1;
            mrhb_pkg::FUNC_CLEAR: cmd_o.do_clear    = 1'b1;
            mrhb_pkg::FUNC_QUERY: cmd_o.load_status = 1'b1;
            mrhb_pkg::FUNC_READ: begin
              if (sts_i.read_empty) begin
                cmd_o.load_status = 1'b1;
              end else begin
                cmd_o.start_read = 1'b1;
                state_d          = S_FETCH;
              end
            end
            default: cmd_o = '0;
          endcase
        end
      end
      S_FETCH: begin
        // ram data stays put until the output slot frees up
        if (sts_i.slot_free) begin
          cmd_o.load_word = 1'b1;
          if (sts_i.run_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.next_read = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/mrhb_dp.sv -----
// datapath: ring heads and counts, word memory, drain cursor, output register
module mrhb_dp #(
  parameter int unsigned RING_DEPTH = mrhb_pkg::RingDepthDef,
  parameter int unsigned RING_COUNT = mrhb_pkg::RingCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mrhb_pkg::BufIdW-1:0] buffer_id_i,
  input  logic [mrhb_pkg::DataW-1:0]  data_in_i,
  input  mrhb_pkg::ctrl_cmd_t         cmd_i,
  output mrhb_pkg::ctrl_sts_t         sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mrhb_pkg::DataW-1:0]  data_out_o,
  output logic [mrhb_pkg::CountW-1:0] count_o,
  output logic                        has_data_o,
  output logic                        last_o
);

  // only rings that buffer_id can name get storage
  localparam int unsigned MaxRings  = 2 ** mrhb_pkg::BufIdW;
  localparam int unsigned LiveRings = (RING_COUNT < MaxRings) ? RING_COUNT : MaxRings;
  localparam int unsigned RingW     = (LiveRings > 1) ? $clog2(LiveRings) : 1;
  localparam int unsigned HeadW     = $clog2(RING_DEPTH);
  localparam int unsigned CntW      = $clog2(RING_DEPTH + 1);
  localparam int unsigned Words     = LiveRings * RING_DEPTH;
  localparam int unsigned AddrW     = $clog2(Words);
  localparam int unsigned CountW    = mrhb_pkg::CountW;
  localparam int unsigned DataW     = mrhb_pkg::DataW;

  localparam logic [HeadW-1:0] LastSlot = HeadW'(RING_DEPTH - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(RING_DEPTH);
  localparam logic [AddrW-1:0] DepthA   = AddrW'(RING_DEPTH);

  logic [HeadW-1:0] head_q [LiveRings];
  logic [CntW-1:0]  cnt_q  [LiveRings];

  logic             present;
  logic [RingW-1:0] sel;
  logic [HeadW-1:0] cur_head;
  logic [CntW-1:0]  cur_cnt;
  logic [AddrW-1:0] base;

  // drain run state
  logic [AddrW-1:0] run_base_q;
  logic [HeadW-1:0] rd_slot_q, rd_slot_d;
  logic [CntW-1:0]  run_n_q;
  logic [CntW-1:0]  rem_q;

  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [DataW-1:0] ram_rdata;

  logic              out_valid_q;
  logic [DataW-1:0]  data_out_q;
  logic [CountW-1:0] count_q;
  logic              has_data_q;
  logic              last_q;

  logic [CntW+CountW-1:0] cur_cnt_wide;
  logic [CntW+CountW-1:0] run_n_wide;

  assign present  = ({{(32 - mrhb_pkg::BufIdW){1'b0}}, buffer_id_i} < 32'(RING_COUNT));
  assign sel      = buffer_id_i[RingW-1:0];
  assign cur_head = head_q[sel];
  assign cur_cnt  = present ? cnt_q[sel] : '0;
  assign base     = AddrW'(sel) * DepthA;

  // newest word sits one slot behind the head
  always_comb begin
    if (cmd_i.start_read) begin
      rd_slot_d = (cur_head == '0) ? LastSlot : cur_head - HeadW'(1);
      ram_raddr = base + AddrW'(rd_slot_d);
    end else begin
      rd_slot_d = (rd_slot_q == '0) ? LastSlot : rd_slot_q - HeadW'(1);
      ram_raddr = run_base_q + AddrW'(rd_slot_d);
    end
  end

  assign ram_re = cmd_i.start_read || cmd_i.next_read;

  mrhb_ram #(
    .WIDTH (DataW),
    .DEPTH (Words)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_write && present),
    .waddr_i (base + AddrW'(cur_head)),
    .wdata_i (data_in_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LiveRings; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (present) begin
      if (cmd_i.do_write) begin
        head_q[sel] <= (cur_head == LastSlot) ? '0 : cur_head + HeadW'(1);
        if (cnt_q[sel] != FullCnt) begin
          cnt_q[sel] <= cnt_q[sel] + CntW'(1);
        end
      end else if (cmd_i.do_clear) begin
        // stale words are never read back, so the memory is left alone
        head_q[sel] <= '0;
        cnt_q[sel]  <= '0;
      end else if (cmd_i.start_read) begin
        cnt_q[sel] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (cmd_i.start_read) begin
      rem_q <= cur_cnt;
    end else if (cmd_i.load_word) begin
      rem_q <= rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_read) begin
      run_base_q <= base;
      run_n_q    <= cur_cnt;
    end
    if (ram_re) begin
      rd_slot_q <= rd_slot_d;
    end
  end

  assign cur_cnt_wide = {{CountW{1'b0}}, cur_cnt};
  assign run_n_wide   = {{CountW{1'b0}}, run_n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_status || cmd_i.load_word) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_status) begin
      data_out_q <= '0;
      count_q    <= cur_cnt_wide[CountW-1:0];
      has_data_q <= 1'b0;
      last_q     <= 1'b1;
    end else if (cmd_i.load_word) begin
      data_out_q <= ram_rdata;
      count_q    <= run_n_wide[CountW-1:0];
      has_data_q <= 1'b1;
      last_q     <= (rem_q == CntW'(1));
    end
  end

  assign sts_o.slot_free  = !out_valid_q || out_ready_i;
  assign sts_o.read_empty = (cur_cnt == '0);
  assign sts_o.run_last   = (rem_q == CntW'(1));

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;
  assign count_o     = count_q;
  assign has_data_o  = has_data_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/core/multi_ring_history_buffer_top.sv -----
// Multi-ring history buffer: up to four independent rings of RING_DEPTH 32-bit words held in
// one memory. A write stores a word at the ring's head and raises its unread count, which
// saturates at RING_DEPTH so old words get overwritten; a read drains the unread words newest
// first and zeroes the count; a clear empties a ring; a query reports the unread count. A read
// of a ring holding n words first starts the run, then moves one word per cycle through the
// single memory read port, stretched by any output stall. The next item is taken while the
// last result still waits in the output register, provided the sink takes it in the same cycle.
// No clearing pass after reset: the block is ready at once.
module multi_ring_history_buffer_top #(
  parameter int unsigned RING_DEPTH = mrhb_pkg::RingDepthDef,
  parameter int unsigned RING_COUNT = mrhb_pkg::RingCountDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mrhb_req_if.sink          req_i,
  mrhb_rsp_if.source        rsp_o
);

  mrhb_pkg::ctrl_cmd_t cmd;
  mrhb_pkg::ctrl_sts_t sts;

  mrhb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_func_i  (req_i.func),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mrhb_dp #(
    .RING_DEPTH (RING_DEPTH),
    .RING_COUNT (RING_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .buffer_id_i (req_i.buffer_id),
    .data_in_i   (req_i.data_in),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .data_out_o  (rsp_o.data_out),
    .count_o     (rsp_o.count),
    .has_data_o  (rsp_o.has_data),
    .last_o      (rsp_o.last)
  );

endmodule

// ----- bench/tb_top.sv -----
// self-checking testbench of the multi-ring history buffer
module tb_top;

  localparam int unsigned Depth      = mrhb_pkg::RingDepthDef;
  localparam int unsigned NumRings   = mrhb_pkg::RingCountDef;
  localparam int unsigned HeadW      = $clog2(Depth);
  localparam int unsigned RandItems  = 134;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    mrhb_pkg::func_e                  func;
    logic [mrhb_pkg::BufIdW-1:0]      buffer_id;
    logic [mrhb_pkg::DataW-1:0]       data;
  } ring_op_t;

  typedef struct packed {
    logic [mrhb_pkg::DataW-1:0]       data_out;
    logic [mrhb_pkg::CountW-1:0]      count;
    logic                             has_data;
    logic                             last;
  } ring_rsp_t;

  logic clk_i;
  logic rst_ni;

  mrhb_req_if req_if ();
  mrhb_rsp_if rsp_if ();

  multi_ring_history_buffer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predicted ring contents
  logic [mrhb_pkg::DataW-1:0]  ring_words  [NumRings][Depth] = '{default: '0};
  logic [HeadW-1:0]            ring_head   [NumRings]        = '{default: '0};
  logic [mrhb_pkg::CountW-1:0] ring_unread [NumRings]        = '{default: '0};

  ring_op_t  pending_ops[$];
  ring_rsp_t expected_rsps[$];
  ring_op_t  offered_op;
  ring_rsp_t seen_rsp;
  ring_rsp_t wanted_rsp;

  int unsigned op_total;
  int unsigned accepted_ops;
  int unsigned err_cnt = 0;
  int unsigned hold_left;
  int unsigned hold_at;
  logic        hold_done;
  int unsigned cycle_cnt = 0;

  function automatic logic [mrhb_pkg::DataW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_op(mrhb_pkg::func_e f, int unsigned ring,
                                 logic [mrhb_pkg::DataW-1:0] word);
    ring_op_t op;
    op.func      = f;
    op.buffer_id = ring[mrhb_pkg::BufIdW-1:0];
    op.data      = word;
    pending_ops.push_back(op);
  endfunction

  // updates the predicted rings and queues the responses one request causes
  function automatic void apply_ring_op(ring_op_t op);
    int unsigned r;
    int unsigned n;
    int unsigned slot;
    logic        present;
    ring_rsp_t   rsp;
    r       = op.buffer_id;
    present = (r < NumRings);
    case (op.func)
      mrhb_pkg::FUNC_WRITE: begin
        if (present) begin
          ring_words[r][ring_head[r]] = op.data;
          ring_head[r] = HeadW'((ring_head[r] + 1) % Depth);
          if (ring_unread[r] < Depth) ring_unread[r] = ring_unread[r] + 1'b1;
        end
      end
      mrhb_pkg::FUNC_CLEAR: begin
        if (present) begin
          ring_head[r]   = '0;
          ring_unread[r] = '0;
          for (int i = 0; i < Depth; i++) ring_words[r][i] = '0;
        end
      end
      mrhb_pkg::FUNC_QUERY: begin
        rsp = '{data_out: '0, count: present ? ring_unread[r] : '0, has_data: 1'b0,
                last: 1'b1};
        expected_rsps.push_back(rsp);
      end
      default: begin
        n = present ? ring_unread[r] : 0;
        if (n == 0) begin
          rsp = '{data_out: '0, count: '0, has_data: 1'b0, last: 1'b1};
          expected_rsps.push_back(rsp);
        end else begin
          // newest word first, walking back from the head
          for (int unsigned i = 0; i < n; i++) begin
            slot = (ring_head[r] + Depth - 1 - i) % Depth;
            rsp = '{data_out: ring_words[r][slot], count: n[mrhb_pkg::CountW-1:0],
                    has_data: 1'b1, last: (i + 1 == n)};
            expected_rsps.push_back(rsp);
          end
          ring_unread[r] = '0;
        end
      end
    endcase
  endfunction

  // idling per phase: sender light and receiver heavy, then swapped, then none
  function automatic int unsigned phase_of(int unsigned done);
    if (done < op_total / 3) return 0;
    if (done < 2 * op_total / 3) return 1;
    return 2;
  endfunction

  function automatic int unsigned send_idle_pct(int unsigned done);
    case (phase_of(done))
      0: return 19;
      1: return 67;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct(int unsigned done);
    case (phase_of(done))
      0: return 67;
      1: return 19;
      default: return 0;
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.func      <= mrhb_pkg::FUNC_WRITE;
      req_if.buffer_id <= '0;
      req_if.data_in   <= '0;
      accepted_ops     <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_ring_op(offered_op);
        accepted_ops <= accepted_ops + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_ops.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct(accepted_ops)) begin
          offered_op = pending_ops.pop_front();
          req_if.valid     <= 1'b1;
          req_if.func      <= offered_op.func;
          req_if.buffer_id <= offered_op.buffer_id;
          req_if.data_in   <= offered_op.data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long output stall while requests keep coming, so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_ops >= hold_at) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // response monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen_rsp = '{data_out: rsp_if.data_out, count: rsp_if.count,
                     has_data: rsp_if.has_data, last: rsp_if.last};
        if (expected_rsps.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected response: data_out=%h count=%0d has_data=%b last=%b",
                     seen_rsp.data_out, seen_rsp.count, seen_rsp.has_data, seen_rsp.last);
          err_cnt = err_cnt + 1;
        end else begin
          wanted_rsp = expected_rsps.pop_front();
          if (seen_rsp.data_out !== wanted_rsp.data_out || seen_rsp.count !== wanted_rsp.count ||
              seen_rsp.has_data !== wanted_rsp.has_data || seen_rsp.last !== wanted_rsp.last) begin
            if (err_cnt < 10) begin
              $display("mismatch: exp data_out=%h count=%0d has_data=%b last=%b",
                       wanted_rsp.data_out, wanted_rsp.count, wanted_rsp.has_data,
                       wanted_rsp.last);
              $display("          got data_out=%h count=%0d has_data=%b last=%b",
                       seen_rsp.data_out, seen_rsp.count, seen_rsp.has_data, seen_rsp.last);
            end
            err_cnt = err_cnt + 1;
          end
        end
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct(accepted_ops));
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned ring;
    int unsigned sel;
    int unsigned burst;
    int unsigned directed;
    rst_ni = 1'b0;

    // empty rings first, then fill two past saturation so the oldest words wrap
    add_op(mrhb_pkg::FUNC_READ, 0, pick_word());
    add_op(mrhb_pkg::FUNC_QUERY, 1, pick_word());
    add_op(mrhb_pkg::FUNC_WRITE, 3, '0);
    add_op(mrhb_pkg::FUNC_WRITE, 3, '1);
    for (int i = 0; i < Depth; i++) add_op(mrhb_pkg::FUNC_WRITE, 3, $urandom);
    add_op(mrhb_pkg::FUNC_QUERY, 3, '0);
    add_op(mrhb_pkg::FUNC_READ, 3, '1);
    add_op(mrhb_pkg::FUNC_WRITE, 3, $urandom);
    add_op(mrhb_pkg::FUNC_CLEAR, 3, $urandom);
    add_op(mrhb_pkg::FUNC_READ, 3, $urandom);
    add_op(mrhb_pkg::FUNC_QUERY, 3, $urandom);
    directed = pending_ops.size();

    // write bursts drained by reads, with loose ops mixed in
    while (pending_ops.size() < directed + RandItems) begin
      sel  = $urandom_range(0, 99);
      ring = $urandom_range(0, 3);
      if (sel < 35) begin
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(Depth, Depth + 6)
                                            : $urandom_range(1, 8);
        for (int unsigned k = 0; k < burst; k++) begin
          add_op(mrhb_pkg::FUNC_WRITE, ring, pick_word());
        end
        if ($urandom_range(0, 2) == 0) add_op(mrhb_pkg::FUNC_QUERY, ring, pick_word());
        add_op(mrhb_pkg::FUNC_READ, ring, pick_word());
      end else if (sel < 60) begin
        add_op(mrhb_pkg::FUNC_WRITE, ring, pick_word());
      end else if (sel < 78) begin
        add_op(mrhb_pkg::FUNC_READ, ring, pick_word());
      end else if (sel < 92) begin
        add_op(mrhb_pkg::FUNC_QUERY, ring, pick_word());
      end else begin
        add_op(mrhb_pkg::FUNC_CLEAR, ring, pick_word());
      end
    end
    op_total = pending_ops.size();
    hold_at  = 2 * op_total / 3 + 4;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(accepted_ops == op_total && expected_rsps.size() == 0)) @(posedge clk_i);
    repeat (Depth + 20) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
